FILE: rtl/core/rsmst_pkg.sv
// Shared constants for the range second-minimum sparse table block.
`default_nettype none

package rsmst_pkg;

    // default sizing
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;
    localparam int VALUE_WIDTH_DEF  = 32;

    // fixed field widths on the stream ports
    localparam int VALUE_FIELD_W = 32;
    localparam int POS_FIELD_W   = 11;

    // input word layout, lowest bit first: value, left, right, zero fill
    localparam int VALUE_LSB  = 0;
    localparam int LEFT_LSB   = VALUE_LSB + VALUE_FIELD_W;
    localparam int RIGHT_LSB  = LEFT_LSB + POS_FIELD_W;
    localparam int S_PAYLOAD_W = RIGHT_LSB + POS_FIELD_W;
    localparam int S_TDATA_W  = ((S_PAYLOAD_W + 7) / 8) * 8;

    // result word: second_value only
    localparam int M_TDATA_W  = VALUE_FIELD_W;

    // tuser codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/range_second_minimum_sparse_table.sv
// Top level: sparse table of (min, second min) pairs with load and range query.
`default_nettype none

// Range second-minimum engine. Each input word either appends one signed
// element (tuser = 0) or asks for the second-smallest element between the
// 1-based positions left..right (tuser = 1). Appends give no result; every
// query gives one result word, with tuser = 1 and data 0 when the range is
// reversed, touches position 0 or runs past the loaded elements. Values are
// assumed distinct; equal values merge by value. The table lives in a single
// memory with one read and one write port, and one shared pair-merge unit
// serves both loads and queries. After an append, s_tready stays low while
// the block writes the new element at level 0 (ST_LOAD0) and then walks the
// table levels in ST_LOAD, one table level per cycle, paced by the single read
// port. A query keeps s_tready low through ST_QCALC, ST_QRDA, ST_QRDB and
// ST_QOUT (ST_QCALC and ST_QOUT for a malformed range) plus any wait for the
// result register, and its result word is registered at the end of that time.
// Appends past MAX_ELEMENTS are dropped in the cycle they arrive.
module range_second_minimum_sparse_table #(
    parameter int MAX_ELEMENTS = rsmst_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = rsmst_pkg::LEVELS_DEF,
    parameter int VALUE_WIDTH  = rsmst_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rsmst_pkg::S_TDATA_W-1:0] s_tdata,  // value, left, right, zero fill
    input  wire logic [0:0]                      s_tuser,  // mode
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rsmst_pkg::M_TDATA_W-1:0]      m_tdata,  // second_value
    output logic [0:0]                           m_tuser   // status
);

    localparam int FW    = rsmst_pkg::POS_FIELD_W;
    localparam int POS_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int ILV_W = $clog2(LEVELS + 1);
    localparam int MW0   = (CNT_W > FW) ? CNT_W : FW;
    localparam int EW    = ((MW0 > LEVELS) ? MW0 : LEVELS) + 1;
    localparam int OW    = rsmst_pkg::VALUE_FIELD_W;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] hi;
        logic signed [VALUE_WIDTH-1:0] lo;
    } pair_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_LOAD,
        ST_QCALC,
        ST_QRDA,
        ST_QRDB,
        ST_QOUT
    } state_t;

    // Pair merge: two singletons give (min, max); otherwise a two-step merge
    // that advances both sides on equal values.
    function automatic pair_t merge_pair(input pair_t a, input pair_t b);
        pair_t                         r;
        logic                          ia;
        logic                          ib;
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] y;
        if (a.lo == a.hi && b.lo == b.hi) begin
            if (a.lo < b.lo) begin
                r.lo = a.lo;
                r.hi = b.lo;
            end else begin
                r.lo = b.lo;
                r.hi = a.lo;
            end
        end else begin
            ia   = (a.lo <= b.lo);
            ib   = (b.lo <= a.lo);
            r.lo = ia ? a.lo : b.lo;
            x    = ia ? a.hi : a.lo;
            y    = ib ? b.hi : b.lo;
            r.hi = (x < y) ? x : y;
        end
        return r;
    endfunction

    // control state
    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ILV_W-1:0]   iss_lvl_reg;
    logic               pend_reg;
    logic               m_tvalid_reg;

    // payload registers
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic [FW-1:0]      left_reg;
    logic [FW-1:0]      right_reg;
    logic [LVL_W-1:0]   pend_lvl_reg;
    logic [POS_W-1:0]   pend_pos_reg;
    logic [LVL_W-1:0]   k_reg;
    logic [POS_W-1:0]   pos_a_reg;
    logic [POS_W-1:0]   pos_b_reg;
    logic               bad_reg;
    pair_t              opnd_reg;
    pair_t              rd_data_reg;
    logic [OW-1:0]      m_tdata_reg;
    logic               m_tuser_reg;

    // table memory, one row per level
    pair_t              tbl_mem [LEVELS][MAX_ELEMENTS];

    logic               s_acc;
    logic [EW-1:0]      np1;
    logic [EW-1:0]      span_iss;
    logic [EW-1:0]      iss_pos_e;
    logic               iss_ok;
    logic [LVL_W-1:0]   iss_rd_lvl;
    logic [LVL_W-1:0]   pend_wr_lvl;
    logic [FW-1:0]      q_d;
    logic [LVL_W-1:0]   q_k;
    logic               q_bad;
    logic [EW-1:0]      q_pos_a_e;
    logic [EW-1:0]      q_pos_b_e;
    logic               out_free;
    pair_t              mrg_a;
    pair_t              mrg_b;
    pair_t              merged;
    logic [LVL_W-1:0]   rd_lvl;
    logic [POS_W-1:0]   rd_pos;
    logic               wr_en;
    logic [LVL_W-1:0]   wr_lvl;
    logic [POS_W-1:0]   wr_pos;
    pair_t              wr_data;
    logic signed [OW-1:0] res_value;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // load walk: level i reads entry (i-1, n+1-2^i) and merges it with the
    // pair just written at level i-1, which is the right half of the window
    assign np1         = EW'(cnt_reg) + EW'(1);
    assign span_iss    = EW'(1) << iss_lvl_reg;
    assign iss_pos_e   = np1 - span_iss;
    assign iss_ok      = (iss_lvl_reg < ILV_W'(LEVELS)) && (span_iss <= np1);
    assign iss_rd_lvl  = LVL_W'(iss_lvl_reg - ILV_W'(1));
    assign pend_wr_lvl = pend_lvl_reg;

    // query decode
    assign q_bad = (left_reg == '0) || (right_reg == '0) || (left_reg > right_reg) ||
                   (EW'(right_reg) > EW'(cnt_reg));
    assign q_d   = right_reg - left_reg;

    // floor(log2(right - left)), capped at the top level
    always_comb begin
        q_k = '0;
        for (int b = 1; b < FW; b++) begin
            if ((q_d >> b) != '0 && b < LEVELS) begin
                q_k = LVL_W'(b);
            end
        end
    end

    assign q_pos_a_e = EW'(left_reg) - EW'(1);
    assign q_pos_b_e = EW'(right_reg) - (EW'(1) << q_k);

    // shared merge unit; left == right reads one entry twice and the merge
    // of a singleton with itself returns that element
    assign mrg_a  = (state_reg == ST_LOAD) ? rd_data_reg : opnd_reg;
    assign mrg_b  = (state_reg == ST_LOAD) ? opnd_reg : rd_data_reg;
    assign merged = merge_pair(mrg_a, mrg_b);

    assign res_value = OW'(merged.hi);

    // memory port steering
    always_comb begin
        rd_lvl  = k_reg;
        rd_pos  = pos_b_reg;
        wr_en   = 1'b0;
        wr_lvl  = pend_wr_lvl;
        wr_pos  = pend_pos_reg;
        wr_data = merged;
        unique case (state_reg)
            ST_LOAD0: begin
                wr_en   = 1'b1;
                wr_lvl  = '0;
                wr_pos  = cnt_reg[POS_W-1:0];
                wr_data = '{hi: value_reg, lo: value_reg};
            end
            ST_LOAD: begin
                rd_lvl = iss_rd_lvl;
                rd_pos = iss_pos_e[POS_W-1:0];
                wr_en  = pend_reg;
            end
            ST_QRDA: begin
                rd_pos = pos_a_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_lvl][wr_pos] <= wr_data;
        end
        rd_data_reg <= tbl_mem[rd_lvl][rd_pos];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            iss_lvl_reg  <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // ST_QOUT owns the valid flag in its own cycles
            if (m_tvalid_reg && m_tready && state_reg != ST_QOUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        value_reg <= s_tdata[rsmst_pkg::VALUE_LSB +: VALUE_WIDTH];
                        left_reg  <= s_tdata[rsmst_pkg::LEFT_LSB +: FW];
                        right_reg <= s_tdata[rsmst_pkg::RIGHT_LSB +: FW];
                        if (s_tuser[0] == rsmst_pkg::MODE_QUERY) begin
                            state_reg <= ST_QCALC;
                        end else if (cnt_reg < CNT_W'(MAX_ELEMENTS)) begin
                            state_reg <= ST_LOAD0;
                        end
                    end
                end
                ST_LOAD0: begin
                    opnd_reg    <= '{hi: value_reg, lo: value_reg};
                    iss_lvl_reg <= ILV_W'(1);
                    pend_reg    <= 1'b0;
                    state_reg   <= ST_LOAD;
                end
                ST_LOAD: begin
                    pend_reg <= iss_ok;
                    if (iss_ok) begin
                        iss_lvl_reg  <= iss_lvl_reg + ILV_W'(1);
                        pend_lvl_reg <= LVL_W'(iss_lvl_reg);
                        pend_pos_reg <= iss_pos_e[POS_W-1:0];
                    end
                    if (pend_reg) begin
                        opnd_reg <= merged;
                    end
                    if (!iss_ok && !pend_reg) begin
                        cnt_reg   <= CNT_W'(np1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_QCALC: begin
                    bad_reg   <= q_bad;
                    k_reg     <= q_k;
                    pos_a_reg <= q_pos_a_e[POS_W-1:0];
                    pos_b_reg <= q_pos_b_e[POS_W-1:0];
                    state_reg <= q_bad ? ST_QOUT : ST_QRDA;
                end
                ST_QRDA: begin
                    state_reg <= ST_QRDB;
                end
                ST_QRDB: begin
                    opnd_reg  <= rd_data_reg;
                    state_reg <= ST_QOUT;
                end
                ST_QOUT: begin
                    // read address holds on the second window, so the data waits too
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= bad_reg ? rsmst_pkg::STATUS_ERR : rsmst_pkg::STATUS_OK;
                        m_tdata_reg  <= bad_reg ? '0 : res_value;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rsmst_checker.sv
// Port-level checks for the range second-minimum block, bound to the top level.
`default_nettype none

module rsmst_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [rsmst_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [0:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rsmst_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]                      m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // error results carry zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == rsmst_pkg::STATUS_ERR |-> m_tdata == '0)
        else $error("error result with nonzero data");

    // a query keeps the block busy for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == rsmst_pkg::MODE_QUERY |=> !s_tready)
        else $error("ready right after a query word");

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind range_second_minimum_sparse_table rsmst_checker u_rsmst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the range second-minimum sparse table block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing
    localparam int RANDOM_PER_PHASE = 643;   // three phases, ~1950 words with directed part
    localparam int LONG_HOLD        = 300;   // receiver hold-off, long enough to back up the block
    localparam int DRAIN_CYCLES     = 40;    // covers the table walk of a late append
    localparam int CYCLE_LIMIT      = 600000;
    localparam int REPORT_MAX       = 10;

    typedef logic signed [rsmst_pkg::VALUE_FIELD_W-1:0] elem_t;

    // One input word plus the pacing hints the driver acts on
    typedef struct packed {
        logic                                mode;
        logic [rsmst_pkg::VALUE_FIELD_W-1:0] value;
        logic [rsmst_pkg::POS_FIELD_W-1:0]   left_pos;
        logic [rsmst_pkg::POS_FIELD_W-1:0]   right_pos;
        logic [1:0]                          phase;        // selects the idle mix
        logic                                drain_first;  // hold until every answer is back
        logic                                hold_recv;    // ask the receiver for a long hold-off
    } stim_item_t;

    // (smallest, second smallest) over one power-of-two window
    typedef struct packed {
        elem_t lo;
        elem_t hi;
    } min_pair_t;

    typedef struct packed {
        logic [rsmst_pkg::VALUE_FIELD_W-1:0] second_value;
        logic                                status;
    } answer_t;

    // Idle percentages per phase: receiver-heavy stalls, then swapped, then none
    int sender_idle_pct [3] = '{25, 69, 0};
    int recv_idle_pct   [3] = '{69, 25, 0};

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rsmst_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]                      s_tuser  = rsmst_pkg::MODE_LOAD;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rsmst_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;

    // Stimulus and scoreboard state
    stim_item_t pending_items [$];
    answer_t    answers_due [$];
    stim_item_t in_flight;
    min_pair_t  span_table [rsmst_pkg::LEVELS_DEF][rsmst_pkg::MAX_ELEMENTS_DEF];
    int unsigned elements_held = 0;

    int cycle_count    = 0;
    int queries_sent   = 0;   // driver side, blocking
    int words_received = 0;   // monitor side, NBA so the driver reads a stable value
    int mismatches     = 0;
    int loads_taken    = 0;
    int loads_dropped  = 0;
    int queries_bad    = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    logic [1:0] cur_phase = 2'd0;

    range_second_minimum_sparse_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // value, left, right, zero fill
        .s_tuser  (s_tuser),   // mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // second_value
        .m_tuser  (m_tuser)    // status
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Merge two window pairs exactly as the hardware rule states: two singletons
    // sort directly, otherwise a two-way merge that steps both sides on a tie.
    function automatic min_pair_t combine_pairs(min_pair_t a, min_pair_t b);
        elem_t       av [2];
        elem_t       bv [2];
        elem_t       res [2];
        elem_t       x;
        elem_t       y;
        int unsigned ia;
        int unsigned ib;
        min_pair_t   r;
        ia = 0;
        ib = 0;
        if (a.lo == a.hi && b.lo == b.hi) begin
            if ($signed(a.lo) < $signed(b.lo)) begin
                r.lo = a.lo;
                r.hi = b.lo;
            end else begin
                r.lo = b.lo;
                r.hi = a.lo;
            end
            return r;
        end
        av[0] = a.lo;
        av[1] = a.hi;
        bv[0] = b.lo;
        bv[1] = b.hi;
        for (int k = 0; k < 2; k++) begin
            x = av[ia & 1];
            y = bv[ib & 1];
            if (x == y) begin
                res[k] = x;
                ia++;
                ib++;
            end else if ($signed(x) < $signed(y)) begin
                res[k] = x;
                ia++;
            end else begin
                res[k] = y;
                ib++;
            end
        end
        r.lo = res[0];
        r.hi = res[1];
        return r;
    endfunction

    // Apply one accepted word to the shadow table; queries queue their answer.
    task automatic predict_second_min(input stim_item_t it);
        min_pair_t   p;
        answer_t     ans;
        int unsigned n;
        int unsigned span;
        int unsigned half;
        int unsigned j;
        int unsigned d;
        int unsigned k;
        int unsigned l;
        int unsigned r;
        if (it.mode == rsmst_pkg::MODE_LOAD) begin
            n = elements_held;
            if (n >= rsmst_pkg::MAX_ELEMENTS_DEF) begin
                loads_dropped++;
                return;
            end
            p.lo = it.value;
            p.hi = it.value;
            span_table[0][n] = p;
            // every level whose window now ends at the new element
            for (int i = 1; i < rsmst_pkg::LEVELS_DEF; i++) begin
                span = 1 << i;
                half = 1 << (i - 1);
                if (span > n + 1)
                    break;
                j = n + 1 - span;
                span_table[i][j] = combine_pairs(span_table[i-1][j], span_table[i-1][j+half]);
            end
            elements_held = n + 1;
            loads_taken++;
        end else begin
            l = 32'(it.left_pos);
            r = 32'(it.right_pos);
            queries_sent++;
            if (l == 0 || r == 0 || l > r || r > elements_held) begin
                ans.second_value = '0;
                ans.status       = rsmst_pkg::STATUS_ERR;
                queries_bad++;
            end else if (l == r) begin
                ans.second_value = span_table[0][l-1].lo;
                ans.status       = rsmst_pkg::STATUS_OK;
            end else begin
                // two overlapping level-k windows, k = floor(log2(r - l))
                d = r - l;
                k = 0;
                while (k + 1 < rsmst_pkg::LEVELS_DEF && (d >> (k + 1)) != 0)
                    k++;
                p = combine_pairs(span_table[k][l-1], span_table[k][r - (1 << k)]);
                ans.second_value = p.hi;
                ans.status       = rsmst_pkg::STATUS_OK;
            end
            answers_due.insert(answers_due.size(), ans);
        end
    endtask

    function automatic stim_item_t make_item(logic mode, logic [31:0] value, int l, int r);
        stim_item_t it;
        it           = '0;
        it.mode      = mode;
        it.value     = value;
        it.left_pos  = l[rsmst_pkg::POS_FIELD_W-1:0];
        it.right_pos = r[rsmst_pkg::POS_FIELD_W-1:0];
        return it;
    endfunction

    // Append one word at the tail of the stimulus queue.
    task automatic queue_item(input stim_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic stim_item_t random_load();
        stim_item_t  it;
        int unsigned pick;
        it = make_item(rsmst_pkg::MODE_LOAD, $urandom, $urandom_range(0, 2047),
                       $urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.value = $urandom_range(0, 15);   // small pool, so duplicates occur
        end else if (pick < 15) begin
            case ($urandom_range(0, 3))
                0:       it.value = 32'h8000_0000;
                1:       it.value = 32'h7FFF_FFFF;
                2:       it.value = 32'h0000_0000;
                default: it.value = 32'hFFFF_FFFF;
            endcase
        end
        return it;
    endfunction

    // Mostly well-formed ranges over what is loaded so far, some malformed ones.
    function automatic stim_item_t random_query(int unsigned loaded);
        stim_item_t  it;
        int unsigned pick;
        int unsigned l;
        int unsigned r;
        it   = make_item(rsmst_pkg::MODE_QUERY, $urandom, 0, 0);
        pick = $urandom_range(0, 99);
        if (loaded == 0 || pick < 15) begin
            case ($urandom_range(0, 4))
                0: begin
                    l = 0;
                    r = $urandom_range(0, 2047);
                end
                1: begin
                    l = $urandom_range(1, 2047);
                    r = 0;
                end
                2: begin
                    // reversed range
                    l = (loaded >= 2) ? $urandom_range(2, loaded) : 2;
                    r = $urandom_range(1, l - 1);
                end
                3: begin
                    // runs past the loaded elements
                    r = $urandom_range(loaded + 1, 2047);
                    l = $urandom_range(1, r);
                end
                default: begin
                    l = $urandom_range(0, 2047);
                    r = $urandom_range(0, 2047);
                end
            endcase
        end else if (pick < 25) begin
            l = $urandom_range(1, loaded);
            r = l;
        end else if (pick < 30) begin
            l = 1;
            r = loaded;
        end else if (pick < 70) begin
            l = $urandom_range(1, loaded);
            r = l + $urandom_range(1, 16);
            if (r > loaded)
                r = loaded;
        end else begin
            l = $urandom_range(1, loaded);
            r = $urandom_range(l, loaded);
        end
        it.left_pos  = l[rsmst_pkg::POS_FIELD_W-1:0];
        it.right_pos = r[rsmst_pkg::POS_FIELD_W-1:0];
        return it;
    endfunction

    // Driver: takes the next word from pending_items whenever the bus is free.
    always @(posedge aclk) begin
        logic [rsmst_pkg::S_TDATA_W-1:0] word;
        stim_item_t                      nxt;
        logic                            offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_second_min(in_flight);
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (pending_items.size() != 0) begin
                    nxt   = pending_items[0];
                    offer = ($urandom_range(0, 99) >= sender_idle_pct[nxt.phase]);
                    // pause point: nothing new until every answer is back
                    if (nxt.drain_first && queries_sent != words_received)
                        offer = 1'b0;
                end
                if (offer) begin
                    in_flight = pending_items.pop_front();
                    word = '0;
                    word[rsmst_pkg::VALUE_LSB +: rsmst_pkg::VALUE_FIELD_W] = in_flight.value;
                    word[rsmst_pkg::LEFT_LSB  +: rsmst_pkg::POS_FIELD_W]   = in_flight.left_pos;
                    word[rsmst_pkg::RIGHT_LSB +: rsmst_pkg::POS_FIELD_W]   = in_flight.right_pos;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= word;
                    s_tuser   <= in_flight.mode;
                    cur_phase <= in_flight.phase;
                    if (in_flight.hold_recv)
                        hold_requests <= hold_requests + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern, with a long hold-off when the driver asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
        end
    end

    task automatic report_mismatch(input string what, input answer_t want, input answer_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected value %0d status %0b, got value %0d status %0b",
                     $realtime, what, $signed(want.second_value), want.status,
                     $signed(got.second_value), got.status);
    endtask

    // Monitor: every accepted result word against the oldest expected answer.
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.second_value = m_tdata;
            got.status       = m_tuser[0];
            words_received  <= words_received + 1;
            if (answers_due.size() == 0) begin
                report_mismatch("result with no query pending", '0, got);
            end else begin
                want = answers_due.pop_front();
                if (got.second_value !== want.second_value || got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        stim_item_t  it;
        int unsigned gen_loaded;
        gen_loaded = 0;

        // Directed: empty table, extremes, duplicates, every malformed range kind
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 1));      // nothing loaded yet
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'h8000_0000, 2047, 0));
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'h7FFF_FFFF, 0, 2047));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'hFFFF_FFFF, 1, 1));  // single element
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 2));
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'h0, 0, 0));
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'h0, 0, 0));        // duplicate value
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'hFFFF_FFFF, 0, 0));
        queue_item(make_item(rsmst_pkg::MODE_LOAD, 32'h0000_0005, 0, 0));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 3, 4));      // two equal singletons
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 4));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 2, 5));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 5));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 5, 5));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 0, 3));      // left is zero
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 3, 0));      // right is zero
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 4, 2));      // reversed
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 7));      // past loaded count
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 2047, 2047));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1024, 1024));
        queue_item(make_item(rsmst_pkg::MODE_QUERY, 32'h0, 1, 1024));
        gen_loaded = 6;

        // Random: three idle mixes, each opening with a pause until idle and
        // carrying a long receiver hold-off followed by a query burst.
        for (int p = 0; p < 3; p++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n >= 40 && n < 52)
                    it = random_query(gen_loaded);
                else if (gen_loaded < rsmst_pkg::MAX_ELEMENTS_DEF && $urandom_range(0, 99) < 60)
                    it = random_load();
                else if (gen_loaded >= rsmst_pkg::MAX_ELEMENTS_DEF &&
                         $urandom_range(0, 99) < 5)
                    it = random_load();                       // dropped: table is full
                else
                    it = random_query(gen_loaded);
                if (it.mode == rsmst_pkg::MODE_LOAD && gen_loaded < rsmst_pkg::MAX_ELEMENTS_DEF)
                    gen_loaded++;
                it.phase       = p[1:0];
                it.drain_first = (n % 160 == 0);
                it.hold_recv   = (n == 40);
                queue_item(it);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || answers_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        mismatches += answers_due.size();
        $display("Run: %0d appends kept, %0d dropped at capacity, %0d queries (%0d malformed)",
                 loads_taken, loads_dropped, queries_sent, queries_bad);
        $display("Checked %0d result words under three idle mixes and %0d long receiver holds",
                 words_received, hold_requests);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatching result words", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/rsmst_pkg.sv
rtl/core/range_second_minimum_sparse_table.sv
rtl/core/rsmst_checker.sv
bench/testbench.sv
